// ===== rtl/core/fault_code_event_memory_unit_defines.svh =====
// Assertion macros shared by the fault code event memory RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef FAULT_CODE_EVENT_MEMORY_UNIT_DEFINES_SVH
`define FAULT_CODE_EVENT_MEMORY_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clock and switched off while reset is high.
`define FCEM_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and switched off while reset is high.
`define FCEM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/fcem_pkg.sv =====
// Package for the fault code event memory: field widths, codes and shared types.
// No dependencies; the interfaces, the code store, the unit and the testbench import it.
`timescale 1ns / 1ps
`default_nettype none

package fcem_pkg;

   localparam int DTC_W      = 5;
   localparam int BYTE_W     = 8;
   localparam int WORD_W     = 32;
   localparam int CNT_W      = 8;
   localparam int SLOT_OUT_W = 2;
   localparam int MAX_FRAMES = 8;

   // Frame record: voltage, speed, rpm, ignition, gear (gear in the low byte),
   // then reason word, then timestamp.
   localparam int SIG_W   = 5 * BYTE_W;
   localparam int FRAME_W = SIG_W + 2 * WORD_W;

   localparam logic [SLOT_OUT_W-1:0] NO_SLOT = 2'd3;

   localparam logic MODE_REPORT = 1'b0;
   localparam logic MODE_CLEAR  = 1'b1;

   // One code's record. Bit k of occupied is set when slot k holds a frame
   // whose gear byte is nonzero.
   typedef struct packed {
      logic [CNT_W-1:0]      count;
      logic                  active;
      logic [MAX_FRAMES-1:0] occupied;
   } entry_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clear_all;
   } store_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/core/fcem_req_if.sv =====
// Request channel of the fault code event memory: valid/ready plus report fields.
// Depends on fcem_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface fcem_req_if;
   import fcem_pkg::*;

   logic              valid;
   logic              ready;
   logic              mode;
   logic [DTC_W-1:0]  dtc_id;
   logic              fault_active;
   logic [WORD_W-1:0] reason;
   logic [BYTE_W-1:0] gear;
   logic [BYTE_W-1:0] ignition;
   logic [BYTE_W-1:0] rpm;
   logic [BYTE_W-1:0] speed;
   logic [WORD_W-1:0] timestamp;
   logic [BYTE_W-1:0] supply_voltage;

   modport source (
      output valid, mode, dtc_id, fault_active, reason, gear, ignition, rpm, speed,
             timestamp, supply_voltage,
      input  ready
   );

   modport sink (
      input  valid, mode, dtc_id, fault_active, reason, gear, ignition, rpm, speed,
             timestamp, supply_voltage,
      output ready
   );

endinterface

`default_nettype wire

// ===== rtl/core/fcem_rsp_if.sv =====
// Response channel of the fault code event memory: valid/ready plus result fields.
// Depends on fcem_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface fcem_rsp_if;
   import fcem_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  notify;
   logic [DTC_W-1:0]      notified_id;
   logic [CNT_W-1:0]      occurrence_count;
   logic [SLOT_OUT_W-1:0] frame_slot;
   logic                  active_now;

   modport source (
      output valid, notify, notified_id, occurrence_count, frame_slot, active_now,
      input  ready
   );

   modport sink (
      input  valid, notify, notified_id, occurrence_count, frame_slot, active_now,
      output ready
   );

endinterface

`default_nettype wire

// ===== rtl/core/fcem_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fcem_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic                                      rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/fcem_code_store.sv =====
// Per-code record store: counter, active flag and slot occupancy in one RAM,
// with a valid bit per code so reset and clear take effect at once. Uses fcem_ram.
`timescale 1ns / 1ps
`default_nettype none

module fcem_code_store #(
   parameter int NUM_CODES = 32
) (
   input  wire logic                                              clock,
   input  wire logic                                              reset,
   input  wire fcem_pkg::store_ctl_type                           ctl,
   input  wire logic [((NUM_CODES > 1) ? $clog2(NUM_CODES) : 1)-1:0] rd_addr,
   input  wire logic [((NUM_CODES > 1) ? $clog2(NUM_CODES) : 1)-1:0] wr_addr,
   input  wire fcem_pkg::entry_type                               wr_data,
   output      fcem_pkg::entry_type                               rd_data
);
   import fcem_pkg::*;

   localparam int ENTRY_W = $bits(entry_type);

   logic [NUM_CODES-1:0] valid_ff;
   logic [NUM_CODES-1:0] valid_in;
   logic                 rd_valid_ff;
   logic [ENTRY_W-1:0]   ram_q;

   fcem_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_CODES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ctl.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (ctl.rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // A code never written since the last reset or clear reads as all zero.
   always_comb begin
      valid_in = valid_ff;
      if (ctl.clear_all) begin
         valid_in = '0;
      end else if (ctl.wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (ctl.rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? entry_type'(ram_q) : '0;

endmodule

`default_nettype wire

// ===== rtl/core/fault_code_event_memory_unit.sv =====
// Fault code event memory: the code record is read when a request is accepted; write-back and
// response load follow in the next cycle, or later while the response is stalled. No new request
// is taken until the pending one has been written back and its response loaded.
// Reset is synchronous; it clears the sequencer, the response valid, the recording switch
// and the per-code valid bits, so the table reads as empty right after reset.
// Depends on fcem_pkg, the channel interfaces, fcem_code_store, fcem_ram and the macros.
`timescale 1ns / 1ps
`default_nettype none
`include "fault_code_event_memory_unit_defines.svh"

module fault_code_event_memory_unit #(
   parameter int NUM_CODES       = 32,
   parameter int FRAMES_PER_CODE = 3
) (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   csr_we,
   input  wire logic   csr_wdata,
   fcem_req_if.sink    req_bus,
   fcem_rsp_if.source  rsp_bus
);
   import fcem_pkg::*;

   localparam int IDX_W  = (NUM_CODES > 1) ? $clog2(NUM_CODES) : 1;
   localparam int SLOT_W = (FRAMES_PER_CODE > 1) ? $clog2(FRAMES_PER_CODE) : 1;
   localparam int NUM_SLOTS = NUM_CODES * FRAMES_PER_CODE;
   localparam int FA_W   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   // Sequencer: IDLE takes a request and launches the record read; EXEC has the
   // record, waits until the response register is free, then writes back and
   // publishes the response.
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff;
   logic state_in;

   // Recording switch from the control register.
   logic csr_disable_ff;

   // The pending request, captured at acceptance.
   logic              pend_mode_ff;
   logic [DTC_W-1:0]  pend_id_ff;
   logic              pend_present_ff;
   logic [WORD_W-1:0] pend_reason_ff;
   logic [SIG_W-1:0]  pend_sig_ff;
   logic [WORD_W-1:0] pend_time_ff;

   // Response register.
   logic                  rsp_valid_ff;
   logic                  rsp_notify_ff;
   logic [DTC_W-1:0]      rsp_id_ff;
   logic [CNT_W-1:0]      rsp_count_ff;
   logic [SLOT_OUT_W-1:0] rsp_slot_ff;
   logic                  rsp_active_ff;

   logic                  rsp_notify_in;
   logic [DTC_W-1:0]      rsp_id_in;
   logic [CNT_W-1:0]      rsp_count_in;
   logic [SLOT_OUT_W-1:0] rsp_slot_in;
   logic                  rsp_active_in;

   logic req_fire;
   logic out_free;
   logic exec_go;

   logic [IDX_W+DTC_W-1:0] req_id_ext;
   logic [IDX_W+DTC_W-1:0] pend_id_ext;
   logic [IDX_W-1:0]       req_idx;
   logic [IDX_W-1:0]       pend_idx;

   store_ctl_type store_ctl;
   entry_type     entry_rd;
   entry_type     entry_wr;

   logic               frame_we;
   logic [FA_W-1:0]    frame_addr;
   logic [FRAME_W-1:0] frame_data;

   assign req_fire       = req_bus.valid && req_bus.ready;
   assign req_bus.ready  = (state_ff == ST_IDLE);
   assign out_free       = !rsp_valid_ff || rsp_bus.ready;
   assign exec_go        = (state_ff == ST_EXEC) && out_free;

   // Code indexes are zero-extended before trimming so any table size works.
   assign req_id_ext  = {{IDX_W{1'b0}}, req_bus.dtc_id};
   assign pend_id_ext = {{IDX_W{1'b0}}, pend_id_ff};
   assign req_idx     = req_id_ext[IDX_W-1:0];
   assign pend_idx    = pend_id_ext[IDX_W-1:0];

   assign frame_data = {pend_sig_ff, pend_reason_ff, pend_time_ff};

   fcem_code_store #(
      .NUM_CODES (NUM_CODES)
   ) u_code_store (
      .clock   (clock),
      .reset   (reset),
      .ctl     (store_ctl),
      .rd_addr (req_idx),
      .wr_addr (pend_idx),
      .wr_data (entry_wr),
      .rd_data (entry_rd)
   );

   // Freeze-frame storage. Whether a slot is taken is tracked in the code record,
   // so this memory is only written; a slot's contents matter only while its
   // occupancy bit is set.
   fcem_ram #(
      .WIDTH (FRAME_W),
      .DEPTH (NUM_SLOTS)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (frame_we),
      .wr_addr (frame_addr),
      .wr_data (frame_data),
      .rd_en   (1'b0),
      .rd_addr ('0),
      .rd_data ()
   );

   // Record update. The next request is taken only after this write-back, so a
   // read never overlaps an unfinished write of the same code.
   always_comb begin
      logic                  id_ok;
      logic                  found;
      logic [SLOT_W-1:0]     k_sel;
      logic [MAX_FRAMES-1:0] occ_set;

      id_ok   = (int'(pend_id_ff) < NUM_CODES);
      found   = 1'b0;
      k_sel   = '0;
      occ_set = '0;

      store_ctl.rd_en     = req_fire;
      store_ctl.wr_en     = 1'b0;
      store_ctl.clear_all = 1'b0;
      entry_wr            = entry_rd;
      frame_we            = 1'b0;
      frame_addr          = '0;

      rsp_notify_in = 1'b0;
      rsp_id_in     = '0;
      rsp_count_in  = '0;
      rsp_slot_in   = NO_SLOT;
      rsp_active_in = 1'b0;

      // First slot whose gear byte was zero when stored, or never stored.
      for (int k = 0; k < FRAMES_PER_CODE; k++) begin
         if (!found && !entry_rd.occupied[k]) begin
            found = 1'b1;
            k_sel = SLOT_W'(k);
         end
      end

      if (pend_mode_ff == MODE_CLEAR) begin
         // Table clear: all valid bits drop at once; recording switch ignored.
         store_ctl.clear_all = exec_go;
      end else if (!id_ok) begin
         // Code outside the table: nothing happens; the result is all zero but for the slot, NO_SLOT.
      end else if (csr_disable_ff) begin
         rsp_count_in  = entry_rd.count;
         rsp_active_in = entry_rd.active;
      end else if (!pend_present_ff) begin
         // Fault gone: only the active flag drops.
         store_ctl.wr_en = exec_go;
         entry_wr.active = 1'b0;
         rsp_count_in    = entry_rd.count;
      end else begin
         // Fault present: count it, mark it active and keep a freeze frame if a
         // slot is free. A frame with a zero gear byte leaves its slot empty.
         store_ctl.wr_en = exec_go;
         entry_wr.count  = entry_rd.count + CNT_W'(1);
         entry_wr.active = 1'b1;
         if (found) begin
            occ_set           = MAX_FRAMES'(pend_sig_ff[BYTE_W-1:0] != '0) << k_sel;
            entry_wr.occupied = entry_rd.occupied | occ_set;
            frame_we          = exec_go;
            frame_addr        = FA_W'(int'(pend_idx) * FRAMES_PER_CODE) + FA_W'(k_sel);
            rsp_slot_in       = SLOT_OUT_W'(k_sel);
         end
         rsp_notify_in = 1'b1;
         rsp_id_in     = pend_id_ff;
         rsp_count_in  = entry_wr.count;
         rsp_active_in = 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      if (req_fire) begin
         state_in = ST_EXEC;
      end else if (exec_go) begin
         state_in = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         csr_disable_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            csr_disable_ff <= csr_wdata;
         end
         if (exec_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         pend_mode_ff    <= req_bus.mode;
         pend_id_ff      <= req_bus.dtc_id;
         pend_present_ff <= req_bus.fault_active;
         pend_reason_ff  <= req_bus.reason;
         pend_sig_ff     <= {req_bus.supply_voltage, req_bus.speed, req_bus.rpm,
                             req_bus.ignition, req_bus.gear};
         pend_time_ff    <= req_bus.timestamp;
      end
      if (exec_go) begin
         rsp_notify_ff <= rsp_notify_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_slot_ff   <= rsp_slot_in;
         rsp_active_ff <= rsp_active_in;
      end
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.notify           = rsp_notify_ff;
   assign rsp_bus.notified_id      = rsp_id_ff;
   assign rsp_bus.occurrence_count = rsp_count_ff;
   assign rsp_bus.frame_slot       = rsp_slot_ff;
   assign rsp_bus.active_now       = rsp_active_ff;

   `FCEM_ASSERT_NEXT(a_accept_to_exec, req_fire, state_ff == ST_EXEC, "accept did not start update")
   `FCEM_ASSERT_NEXT(a_exec_publishes, exec_go, rsp_valid_ff, "update did not publish response")
   `FCEM_ASSERT_IMPLIES(a_write_in_exec, store_ctl.wr_en || frame_we, exec_go && !pend_mode_ff, "record write outside update")
   `FCEM_ASSERT_IMPLIES(a_notify_active, rsp_valid_ff && rsp_notify_ff, rsp_active_ff, "notification without active flag")

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the fault code event memory unit.
// Depends on fcem_pkg, the request and response channel interfaces and the unit itself.
`timescale 1ns / 1ps

module tb_top;
   import fcem_pkg::*;

   localparam int NUM_CODES       = 32;
   localparam int FRAMES_PER_CODE = 3;
   // Cycles without any handshake on either channel before the run is declared hung.
   localparam int STALL_LIMIT     = 3000;

   // One request as the sender sees it.
   typedef struct {
      logic              mode;
      logic [DTC_W-1:0]  dtc_id;
      logic              fault_active;
      logic [WORD_W-1:0] reason;
      logic [BYTE_W-1:0] gear;
      logic [BYTE_W-1:0] ignition;
      logic [BYTE_W-1:0] rpm;
      logic [BYTE_W-1:0] speed;
      logic [WORD_W-1:0] timestamp;
      logic [BYTE_W-1:0] supply_voltage;
   } report_type;

   // One response as the unit should return it.
   typedef struct {
      logic                  notify;
      logic [DTC_W-1:0]      notified_id;
      logic [CNT_W-1:0]      occurrence_count;
      logic [SLOT_OUT_W-1:0] frame_slot;
      logic                  active_now;
   } outcome_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic csr_wdata;

   fcem_req_if req_if ();
   fcem_rsp_if rsp_if ();

   fault_code_event_memory_unit #(
      .NUM_CODES       (NUM_CODES),
      .FRAMES_PER_CODE (FRAMES_PER_CODE)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_bus   (req_if),
      .rsp_bus   (rsp_if)
   );

   // Shadow copy of the event table. Only the gear byte of each freeze frame
   // matters for prediction, since it alone decides whether a slot is free.
   logic [CNT_W-1:0]  shadow_count [NUM_CODES];
   logic              shadow_active [NUM_CODES];
   logic [BYTE_W-1:0] shadow_gear [NUM_CODES][FRAMES_PER_CODE];
   logic              recording_off;

   // Responses still owed by the unit, oldest first.
   outcome_type pending_outcomes [$];

   int fail_count;
   int idle_cycles;

   // Percent chance of a sender gap after each request and of a receiver stall
   // starting in a given cycle; test tasks change these to shape the traffic.
   int sender_gap_pct;
   int receiver_stall_pct;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------

   function automatic void wipe_shadow_table();
      foreach (shadow_count[c]) begin
         shadow_count[c]  = '0;
         shadow_active[c] = 1'b0;
         for (int k = 0; k < FRAMES_PER_CODE; k++) begin
            shadow_gear[c][k] = '0;
         end
      end
   endfunction

   // Applies one accepted request to the shadow table and returns the response
   // that the unit must produce for it.
   function automatic outcome_type apply_report(report_type r);
      outcome_type o;
      logic        stored;
      o.notify           = 1'b0;
      o.notified_id      = '0;
      o.occurrence_count = '0;
      o.frame_slot       = NO_SLOT;
      o.active_now       = 1'b0;
      stored             = 1'b0;

      // A clear wipes everything, whether recording is on or not.
      if (r.mode == MODE_CLEAR) begin
         wipe_shadow_table();
         return o;
      end
      // With recording off the code is only looked up, never touched.
      if (recording_off) begin
         o.occurrence_count = shadow_count[r.dtc_id];
         o.active_now       = shadow_active[r.dtc_id];
         return o;
      end
      // The fault has gone away: drop the active flag, keep the count.
      if (!r.fault_active) begin
         shadow_active[r.dtc_id] = 1'b0;
         o.occurrence_count      = shadow_count[r.dtc_id];
         return o;
      end

      // Fault present: count it (8-bit wrap), mark it active and store the
      // frame in the first slot whose gear byte is zero. A frame with gear zero
      // is written but leaves its slot looking free.
      shadow_count[r.dtc_id]  = shadow_count[r.dtc_id] + CNT_W'(1);
      shadow_active[r.dtc_id] = 1'b1;
      for (int k = 0; k < FRAMES_PER_CODE; k++) begin
         if (!stored && shadow_gear[r.dtc_id][k] == '0) begin
            shadow_gear[r.dtc_id][k] = r.gear;
            o.frame_slot             = SLOT_OUT_W'(k);
            stored                   = 1'b1;
         end
      end
      o.notify           = 1'b1;
      o.notified_id      = r.dtc_id;
      o.occurrence_count = shadow_count[r.dtc_id];
      o.active_now       = 1'b1;
      return o;
   endfunction

   // ---------------------------------------------------------------------------
   // Traffic helpers
   // ---------------------------------------------------------------------------

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      if ($urandom_range(0, 99) < 85) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   // Lowers the request valid and keeps it low for the given number of cycles.
   task automatic hold_requests(input int cycles);
      @(negedge clock);
      req_if.valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Presents one request, waits for it to be taken and records what it must
   // produce. When no gap follows, valid stays high for the next request, so
   // every other caller starts by lowering it at the next falling edge.
   task automatic send_report(input report_type r);
      @(negedge clock);
      req_if.valid          <= 1'b1;
      req_if.mode           <= r.mode;
      req_if.dtc_id         <= r.dtc_id;
      req_if.fault_active   <= r.fault_active;
      req_if.reason         <= r.reason;
      req_if.gear           <= r.gear;
      req_if.ignition       <= r.ignition;
      req_if.rpm            <= r.rpm;
      req_if.speed          <= r.speed;
      req_if.timestamp      <= r.timestamp;
      req_if.supply_voltage <= r.supply_voltage;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      pending_outcomes.push_back(apply_report(r));
      if ($urandom_range(0, 99) < sender_gap_pct) begin
         hold_requests(pick_gap());
      end
   endtask

   // Stops sending and waits until every owed response has come back, then lets
   // the clock run on so the unit is surely idle.
   task automatic wait_for_responses();
      hold_requests(1);
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes the recording switch. Only called while the unit is idle.
   task automatic write_recording_off(input logic value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      recording_off = value;
   endtask

   function automatic report_type fault_report(input logic [DTC_W-1:0] code,
                                               input logic present,
                                               input logic [BYTE_W-1:0] gear);
      report_type r;
      r.mode           = MODE_REPORT;
      r.dtc_id         = code;
      r.fault_active   = present;
      r.reason         = $urandom;
      r.gear           = gear;
      r.ignition       = BYTE_W'($urandom);
      r.rpm            = BYTE_W'($urandom);
      r.speed          = BYTE_W'($urandom);
      r.timestamp      = $urandom;
      r.supply_voltage = BYTE_W'($urandom);
      return r;
   endfunction

   // Random request. Most reports go to a handful of codes so that their
   // frame slots fill up; clears are rare so the table has time to fill.
   function automatic report_type random_report(input int clear_pct);
      report_type r;
      logic [DTC_W-1:0] code;
      logic [BYTE_W-1:0] gear;
      if ($urandom_range(0, 99) < 70) begin
         code = DTC_W'($urandom_range(0, 3)) ^ DTC_W'(5'h0C);
      end else begin
         code = DTC_W'($urandom);
      end
      gear = ($urandom_range(0, 99) < 10) ? '0 : BYTE_W'($urandom);
      r = fault_report(code, $urandom_range(0, 99) < 75, gear);
      if ($urandom_range(0, 99) < clear_pct) begin
         r.mode = MODE_CLEAR;
      end else if ($urandom_range(0, 99) < 3) begin
         // Noise: the fault flag is redrawn at random; the mode bit stays low, so it is still a report.
         r.fault_active = 1'($urandom);
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Walks one code through its slots, gear-zero frames, a full table, the
   // fault going away, field extremes on the last and first codes, and a clear.
   task automatic test_directed_reports();
      report_type r;
      send_report(fault_report(5'd0, 1'b1, 8'd1));      // slot 0
      send_report(fault_report(5'd0, 1'b1, 8'd0));      // slot 1, stays free
      send_report(fault_report(5'd0, 1'b1, 8'hFF));     // slot 1 again
      send_report(fault_report(5'd0, 1'b1, 8'd5));      // slot 2
      send_report(fault_report(5'd0, 1'b1, 8'd9));      // all full, frame dropped
      send_report(fault_report(5'd0, 1'b0, 8'd9));      // fault gone
      send_report(fault_report(5'd0, 1'b0, 8'd0));      // gone twice

      r.mode           = MODE_REPORT;
      r.dtc_id         = '1;
      r.fault_active   = 1'b1;
      r.reason         = '1;
      r.gear           = '1;
      r.ignition       = '1;
      r.rpm            = '1;
      r.speed          = '1;
      r.timestamp      = '1;
      r.supply_voltage = '1;
      send_report(r);
      r.fault_active = 1'b0;
      send_report(r);

      r.mode           = MODE_REPORT;
      r.dtc_id         = '0;
      r.fault_active   = 1'b1;
      r.reason         = '0;
      r.gear           = '0;
      r.ignition       = '0;
      r.rpm            = '0;
      r.speed          = '0;
      r.timestamp      = '0;
      r.supply_voltage = '0;
      send_report(r);                                   // all-zero fields

      r = fault_report(5'd17, 1'b1, 8'd3);
      r.mode = MODE_CLEAR;
      send_report(r);                                   // clear wipes everything
      send_report(fault_report(5'd0, 1'b1, 8'd2));      // counts from zero again
      send_report(fault_report(5'd31, 1'b0, 8'd2));
   endtask

   // With recording off reports only read the table, but a clear still works.
   task automatic test_recording_disabled();
      report_type r;
      wait_for_responses();
      write_recording_off(1'b1);
      send_report(fault_report(5'd0, 1'b1, 8'd4));
      send_report(fault_report(5'd0, 1'b0, 8'd4));
      send_report(fault_report(5'd3, 1'b1, 8'd4));
      r = fault_report(5'd0, 1'b1, 8'd4);
      r.mode = MODE_CLEAR;
      send_report(r);
      send_report(fault_report(5'd0, 1'b1, 8'd4));
      wait_for_responses();
      write_recording_off(1'b0);
   endtask

   // Drives one code past 255 occurrences so its counter wraps. The first part
   // runs back to back with the receiver never stalling.
   task automatic test_counter_wrap();
      logic [DTC_W-1:0] code;
      code = DTC_W'($urandom);
      sender_gap_pct     = 0;
      receiver_stall_pct = 0;
      for (int n = 0; n < 260; n++) begin
         if (n == 130) begin
            sender_gap_pct     = 20;
            receiver_stall_pct = 10;
         end
         send_report(fault_report(code, 1'b1, BYTE_W'($urandom)));
      end
   endtask

   // Random traffic over several phases, switching the recording switch
   // between them. Somewhere in each phase the sender waits for the unit to
   // catch up completely before carrying on.
   task automatic test_random_traffic();
      int quota;
      int pause_at;
      logic off;
      for (int phase = 0; phase < 6; phase++) begin
         off   = (phase == 1 || phase == 4);
         quota = off ? 105 : 215;
         wait_for_responses();
         write_recording_off(off);
         sender_gap_pct     = (phase == 2) ? 0 : 30;
         receiver_stall_pct = (phase == 3) ? 0 : 15;
         pause_at = $urandom_range(10, quota - 10);
         for (int n = 0; n < quota; n++) begin
            if (n == pause_at) begin
               wait_for_responses();
            end
            send_report(random_report(2));
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // Response side: random back-pressure and the checker
   // ---------------------------------------------------------------------------

   initial begin
      int stall_left;
      stall_left  = 0;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
            if ($urandom_range(0, 99) < receiver_stall_pct) begin
               stall_left = pick_gap();
            end
         end
         @(negedge clock);
      end
   end

   task automatic check_field(input string name, input logic [31:0] expected,
                              input logic [31:0] actual);
      if (expected !== actual) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expected,
                  actual);
         fail_count++;
      end
   endtask

   // Every response taken is matched against the oldest owed one.
   always @(posedge clock) begin
      outcome_type exp_o;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_outcomes.size() == 0) begin
            $display("%0t: response with none expected, expected nothing, actual %0h %0h %0h %0h %0h",
                     $time, rsp_if.notify, rsp_if.notified_id, rsp_if.occurrence_count,
                     rsp_if.frame_slot, rsp_if.active_now);
            fail_count++;
         end else begin
            exp_o = pending_outcomes.pop_front();
            check_field("notify", 32'(exp_o.notify), 32'(rsp_if.notify));
            check_field("notified_id", 32'(exp_o.notified_id), 32'(rsp_if.notified_id));
            check_field("occurrence_count", 32'(exp_o.occurrence_count),
                        32'(rsp_if.occurrence_count));
            check_field("frame_slot", 32'(exp_o.frame_slot), 32'(rsp_if.frame_slot));
            check_field("active_now", 32'(exp_o.active_now), 32'(rsp_if.active_now));
         end
      end
   end

   // Hang detection: too long without a request or a response moving.
   always @(posedge clock) begin
      if (reset || (req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
         $display("tb_top: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------

   initial begin
      fail_count            = 0;
      idle_cycles           = 0;
      sender_gap_pct        = 25;
      receiver_stall_pct    = 15;
      recording_off         = 1'b0;
      wipe_shadow_table();
      reset                 = 1'b1;
      csr_we                = 1'b0;
      csr_wdata             = 1'b0;
      req_if.valid          = 1'b0;
      req_if.mode           = MODE_REPORT;
      req_if.dtc_id         = '0;
      req_if.fault_active   = 1'b0;
      req_if.reason         = '0;
      req_if.gear           = '0;
      req_if.ignition       = '0;
      req_if.rpm            = '0;
      req_if.speed          = '0;
      req_if.timestamp      = '0;
      req_if.supply_voltage = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Write the switch once at its reset value before any traffic.
      write_recording_off(1'b0);
      test_directed_reports();
      test_recording_disabled();
      test_counter_wrap();
      test_random_traffic();

      wait_for_responses();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/fcem_pkg.sv
rtl/core/fcem_req_if.sv
rtl/core/fcem_rsp_if.sv
rtl/core/fcem_ram.sv
rtl/core/fcem_code_store.sv
rtl/core/fault_code_event_memory_unit.sv
tb/tb_top.sv
